// ----- hdl/device_join_and_frame_counter_filter_assert.svh -----
// Assertion macros shared by the device join and frame counter filter RTL.
// The macros expect a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef DEVICE_JOIN_AND_FRAME_COUNTER_FILTER_ASSERT_SVH
`define DEVICE_JOIN_AND_FRAME_COUNTER_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DJFC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DJFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/djfc_pkg.sv -----
// Package for the device join and frame counter filter: codes, field widths,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package djfc_pkg;

  localparam int unsigned DEVICE_SLOTS_DEF = 16;

  // Input transaction layout, lowest field first.
  localparam int unsigned HDR_W  = 8;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ID_W   = 64;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned GW_W   = 16;
  localparam int unsigned IN_W   = 136;

  // Output transaction layout, lowest field first, padded to whole bytes.
  localparam int unsigned MTYPE_W   = 3;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned ASLOT_W   = 4;
  localparam int unsigned OUT_W     = 16;

  // Message types from header bits 7..5.
  localparam logic [MTYPE_W-1:0] MT_JOIN_REQ    = 3'd0;
  localparam logic [MTYPE_W-1:0] MT_JOIN_ACCEPT = 3'd1;
  localparam logic [MTYPE_W-1:0] MT_UNCONF_UP   = 3'd2;
  localparam logic [MTYPE_W-1:0] MT_CONF_UP     = 3'd4;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_IGNORED   = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_UNHANDLED = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_SLOT  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_FULL      = 3'd4;

  // Which result the datapath should produce in this cycle.
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_UNHANDLED,
    EMIT_BAD_SLOT,
    EMIT_JOIN_HIT,
    EMIT_JOIN_NEW,
    EMIT_DATA
  } emit_e;

  typedef struct packed {
    logic  load;       // capture the input transaction
    logic  srch_init;  // start the slot search at slot one
    logic  srch_step;  // read one slot and compare the previous one
    logic  data_rd;    // read the slot named by the device address
    emit_e emit;
  } dp_cmd_t;

  typedef struct packed {
    logic join_req;    // captured frame is a join request
    logic data_frame;  // captured frame is a join accept or an uplink
    logic addr_bad;    // device address is zero or beyond the used slots
    logic hit;         // compared slot holds the requested device id
    logic miss;        // search ran past the used slots without a hit
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/djfc_ctrl.sv -----
// Controller state machine of the device join and frame counter filter.
// Depends on djfc_pkg for the command and status structs.
`default_nettype none

module djfc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire djfc_pkg::dp_status_t stat_i,
  output djfc_pkg::dp_cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DATA   = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.srch_init = 1'b0;
    cmd_o.srch_step = 1'b0;
    cmd_o.data_rd   = 1'b0;
    cmd_o.emit      = djfc_pkg::EMIT_NONE;
    s_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.join_req) begin
          cmd_o.srch_init = 1'b1;
          state_d         = ST_SEARCH;
        end else if (stat_i.data_frame) begin
          if (!stat_i.addr_bad) begin
            cmd_o.data_rd = 1'b1;
            state_d       = ST_DATA;
          end else if (stat_i.out_free) begin
            cmd_o.emit = djfc_pkg::EMIT_BAD_SLOT;
            state_d    = ST_IDLE;
          end
        end else if (stat_i.out_free) begin
          cmd_o.emit = djfc_pkg::EMIT_UNHANDLED;
          state_d    = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        // The whole search holds while the output register is occupied.
        if (stat_i.out_free) begin
          if (stat_i.hit) begin
            cmd_o.emit = djfc_pkg::EMIT_JOIN_HIT;
            state_d    = ST_IDLE;
          end else if (stat_i.miss) begin
            cmd_o.emit = djfc_pkg::EMIT_JOIN_NEW;
            state_d    = ST_IDLE;
          end else begin
            cmd_o.srch_step = 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (stat_i.out_free) begin
          cmd_o.emit = djfc_pkg::EMIT_DATA;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/djfc_dpath.sv -----
// Datapath of the device join and frame counter filter: transaction registers,
// slot memories, search counter and output register. Depends on djfc_pkg and the assert header.
`default_nettype none

`include "device_join_and_frame_counter_filter_assert.svh"

module djfc_dpath #(
  parameter int unsigned DEVICE_SLOTS = djfc_pkg::DEVICE_SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [djfc_pkg::IN_W-1:0]     in_data_i,
  input  wire djfc_pkg::dp_cmd_t             cmd_i,
  output djfc_pkg::dp_status_t               stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [djfc_pkg::OUT_W-1:0]         out_data_o
);

  localparam int unsigned AW = $clog2(DEVICE_SLOTS);
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEVICE_SLOTS - 1);

  localparam int unsigned ADDR_LO = djfc_pkg::HDR_W;
  localparam int unsigned ID_LO   = ADDR_LO + djfc_pkg::ADDR_W;
  localparam int unsigned CNT_LO  = ID_LO + djfc_pkg::ID_W;
  localparam int unsigned GW_LO   = CNT_LO + djfc_pkg::CNT_W;

  // Captured transaction.
  logic [djfc_pkg::MTYPE_W-1:0] mtype_q;
  logic [djfc_pkg::ADDR_W-1:0]  addr_q;
  logic [djfc_pkg::ID_W-1:0]    id_q;
  logic [djfc_pkg::CNT_W-1:0]   cnt_q;
  logic [djfc_pkg::GW_W-1:0]    gw_q;

  // Slot memories. Entries above the used count never take part in a compare,
  // so none needs a reset.
  logic [djfc_pkg::ID_W-1:0]  id_mem [DEVICE_SLOTS];
  logic [djfc_pkg::CNT_W-1:0] fc_mem [DEVICE_SLOTS];
  logic [djfc_pkg::CNT_W-1:0] jc_mem [DEVICE_SLOTS];
  logic [djfc_pkg::GW_W-1:0]  gw_mem [DEVICE_SLOTS];

  logic [djfc_pkg::ID_W-1:0]  id_rd_q;
  logic [djfc_pkg::CNT_W-1:0] fc_rd_q;
  logic [djfc_pkg::CNT_W-1:0] jc_rd_q;

  logic [AW-1:0] used_q;
  logic [CW-1:0] idx_q;
  logic [AW-1:0] cmp_idx_q;
  logic          pend_q;

  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          issue;
  logic          full;
  logic          append;
  logic [AW-1:0] new_slot;
  logic [AW-1:0] data_slot;

  logic                        jc_we;
  logic [AW-1:0]               jc_waddr;
  logic [djfc_pkg::CNT_W-1:0]  jc_wdata;
  logic                        fc_we;
  logic [djfc_pkg::CNT_W-1:0]  fc_wdata;

  logic [djfc_pkg::VERDICT_W-1:0] verdict;
  logic                           ack;
  logic [AW-1:0]                  slot;
  logic [AW+3:0]                  slot_wide;

  logic                             out_vld_q;
  logic [djfc_pkg::MTYPE_W-1:0]     out_mtype_q;
  logic [djfc_pkg::VERDICT_W-1:0]   out_verdict_q;
  logic                             out_ack_q;
  logic [djfc_pkg::ASLOT_W-1:0]     out_slot_q;

  // Status toward the controller.
  assign issue     = idx_q <= {1'b0, used_q};
  assign full      = used_q == LAST_SLOT;
  assign new_slot  = used_q + 1'b1;
  assign data_slot = addr_q[AW-1:0];

  always_comb begin
    stat_o.join_req   = 1'b0;
    stat_o.data_frame = 1'b0;
    unique case (mtype_q) inside
      djfc_pkg::MT_JOIN_REQ: begin
        stat_o.join_req = 1'b1;
      end
      djfc_pkg::MT_JOIN_ACCEPT, djfc_pkg::MT_UNCONF_UP, djfc_pkg::MT_CONF_UP: begin
        stat_o.data_frame = 1'b1;
      end
      default: begin
      end
    endcase
    stat_o.addr_bad = (addr_q == '0) || (addr_q > djfc_pkg::ADDR_W'(used_q));
    stat_o.hit      = pend_q && (id_rd_q == id_q);
    stat_o.miss     = !pend_q && !issue;
    stat_o.out_free = !out_vld_q || out_ready_i;
  end

  // Capture the incoming transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mtype_q <= in_data_i[djfc_pkg::HDR_W-1 -: djfc_pkg::MTYPE_W];
      addr_q  <= in_data_i[ADDR_LO +: djfc_pkg::ADDR_W];
      id_q    <= in_data_i[ID_LO +: djfc_pkg::ID_W];
      cnt_q   <= in_data_i[CNT_LO +: djfc_pkg::CNT_W];
      gw_q    <= in_data_i[GW_LO +: djfc_pkg::GW_W];
    end
  end

  // Search pointer, used count and pending compare flag.
  assign append = (cmd_i.emit == djfc_pkg::EMIT_JOIN_NEW) && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      pend_q    <= 1'b0;
      cmp_idx_q <= '0;
      used_q    <= '0;
    end else begin
      if (cmd_i.srch_init) begin
        idx_q  <= CW'(1);
        pend_q <= 1'b0;
      end else if (cmd_i.srch_step) begin
        pend_q    <= issue;
        cmp_idx_q <= idx_q[AW-1:0];
        if (issue) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (append) begin
        used_q <= new_slot;
      end
    end
  end

  // Memory read port, shared by the search and the data frame lookup.
  assign rd_addr = cmd_i.data_rd ? data_slot : idx_q[AW-1:0];
  assign rd_en   = cmd_i.srch_step || cmd_i.data_rd;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      id_rd_q <= id_mem[rd_addr];
      fc_rd_q <= fc_mem[rd_addr];
      jc_rd_q <= jc_mem[rd_addr];
    end
  end

  // Write ports.
  always_comb begin
    jc_we    = 1'b0;
    jc_waddr = new_slot;
    jc_wdata = cnt_q;
    fc_we    = 1'b0;
    fc_wdata = cnt_q;
    case (cmd_i.emit)
      djfc_pkg::EMIT_JOIN_HIT: begin
        jc_we    = cnt_q > jc_rd_q;
        jc_waddr = cmp_idx_q;
      end
      djfc_pkg::EMIT_JOIN_NEW: begin
        // A fresh slot starts at zero, so storing the counter matches the accept test.
        jc_we    = !full;
        fc_we    = !full;
        fc_wdata = '0;
      end
      djfc_pkg::EMIT_DATA: begin
        jc_we    = fc_rd_q == '0;
        jc_waddr = data_slot;
        jc_wdata = '0;
        fc_we    = cnt_q > fc_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (append) begin
      id_mem[new_slot] <= id_q;
      gw_mem[new_slot] <= gw_q;
    end
    if (jc_we) begin
      jc_mem[jc_waddr] <= jc_wdata;
    end
    if (fc_we) begin
      fc_mem[cmd_i.emit == djfc_pkg::EMIT_DATA ? data_slot : new_slot] <= fc_wdata;
    end
  end

  // Result of the current transaction.
  always_comb begin
    verdict = djfc_pkg::VERDICT_IGNORED;
    ack     = 1'b0;
    slot    = '0;
    case (cmd_i.emit)
      djfc_pkg::EMIT_UNHANDLED: begin
        verdict = djfc_pkg::VERDICT_UNHANDLED;
      end
      djfc_pkg::EMIT_BAD_SLOT: begin
        verdict = djfc_pkg::VERDICT_BAD_SLOT;
      end
      djfc_pkg::EMIT_JOIN_HIT: begin
        if (cnt_q > jc_rd_q) begin
          verdict = djfc_pkg::VERDICT_ACCEPTED;
          slot    = cmp_idx_q;
        end
      end
      djfc_pkg::EMIT_JOIN_NEW: begin
        if (full) begin
          verdict = djfc_pkg::VERDICT_FULL;
        end else if (cnt_q != '0) begin
          verdict = djfc_pkg::VERDICT_ACCEPTED;
          slot    = new_slot;
        end
      end
      djfc_pkg::EMIT_DATA: begin
        if (cnt_q > fc_rd_q) begin
          verdict = djfc_pkg::VERDICT_ACCEPTED;
          ack     = mtype_q == djfc_pkg::MT_CONF_UP;
        end
      end
      default: begin
      end
    endcase
  end

  assign slot_wide = {4'b0000, slot};

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit != djfc_pkg::EMIT_NONE) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != djfc_pkg::EMIT_NONE) begin
      out_mtype_q   <= mtype_q;
      out_verdict_q <= verdict;
      out_ack_q     <= ack;
      out_slot_q    <= slot_wide[djfc_pkg::ASLOT_W-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {5'b00000, out_slot_q, out_ack_q, out_verdict_q, out_mtype_q};

  `DJFC_ASSERT_IMPLIES(a_used_bound, 1'b1, used_q <= LAST_SLOT, "used count beyond last slot")
  `DJFC_ASSERT_IMPLIES(a_pend_range, pend_q,
                       (cmp_idx_q != '0) && (cmp_idx_q <= used_q),
                       "compared slot outside used range")
  `DJFC_ASSERT_IMPLIES(a_emit_free, cmd_i.emit != djfc_pkg::EMIT_NONE, stat_o.out_free,
                       "result produced into occupied output register")
  `DJFC_ASSERT_NEXT(a_append_count, append, used_q == $past(used_q) + 1'b1,
                    "append did not advance used count")

endmodule

`default_nettype wire

// ----- hdl/device_join_and_frame_counter_filter.sv -----
// Top level of the device join and frame counter filter.
// Instantiates djfc_ctrl and djfc_dpath; depends on djfc_pkg.
//
// Usage: one parsed frame header enters per transaction on the s_axis group and
// exactly one result transaction leaves on the m_axis group, in order.
// A join request walks the used device slots one per cycle while the output
// register is free, comparing the stored device id that the previous step
// read from the slot memory into a register. A device already stored is
// answered when its compare hits; a new device is answered once every used
// slot has missed, and a full table holds DEVICE_SLOTS - 1 slots.
// Join accepts and uplinks read one slot in the decode state and are answered
// from the data state; bad addresses and unhandled types are answered straight
// from the decode state. One transaction is in work at a time, and the next
// one is accepted in the cycle after the result is registered.
// Reset empties the table at once by clearing the used-slot count; no clearing
// pass runs. While the receiver stalls, a finished result waits in the output
// register and the next transaction can still be accepted and decoded; its
// search or lookup then holds until the output register is free.
`default_nettype none

module device_join_and_frame_counter_filter #(
  parameter int unsigned DEVICE_SLOTS = djfc_pkg::DEVICE_SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Fields from bit 0 up: header_byte[7:0], device_address[39:8],
  // device_id[103:40], frame_count[119:104], gateway_id[135:120].
  input  wire logic [djfc_pkg::IN_W-1:0]  s_axis_tdata,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0 up: message_type[2:0], verdict[5:3], send_ack[6],
  // assigned_slot[10:7], zero padding[15:11].
  output logic [djfc_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready
);

  // Command and status between the sequencer and the datapath.
  djfc_pkg::dp_cmd_t    cmd;
  djfc_pkg::dp_status_t stat;

  djfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  djfc_dpath #(
    .DEVICE_SLOTS (DEVICE_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
